// ===== src/bmp_tvf_pkg.sv =====
`default_nettype none
package bmp_tvf_pkg;

  localparam int unsigned MAX_SIDE     = 64;
  localparam int unsigned HEADER_BYTES = 138;

  localparam int unsigned ROW_W   = 64;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned SIDE_W  = 7;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned HDR_W   = 8;
  localparam int unsigned PHASE_W = 2;

  // register indexes on the config port
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_IMAGE_SIDE = 1'b1;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(384);
  localparam logic [SIDE_W-1:0] IMAGE_SIDE_RST = SIDE_W'(64);

  // row write from the pixel front end to the frame store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  data;
    logic              done;
    logic [SIDE_W-1:0] side;
  } row_wr_t;

  function automatic logic [ROW_W-1:0] side_mask(input logic [SIDE_W-1:0] side);
    logic [ROW_W-1:0] m;
    if (side >= SIDE_W'(ROW_W)) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << side) - ROW_W'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/bmp_tvf_pixel.sv =====
`default_nettype none
module bmp_tvf_pixel (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_fire_i,
  input  wire logic [7:0]                           data_byte_i,
  input  wire logic                                 start_of_file_i,
  input  wire logic [bmp_tvf_pkg::THR_W-1:0]        threshold_i,
  input  wire logic [bmp_tvf_pkg::SIDE_W-1:0]       image_side_i,
  output bmp_tvf_pkg::row_wr_t                      row_wr_o
);

  logic [bmp_tvf_pkg::HDR_W-1:0]   hdr_q, hdr_d, hdr_c;
  logic [bmp_tvf_pkg::PHASE_W-1:0] phase_q, phase_d, phase_c;
  logic [bmp_tvf_pkg::SUM_W-1:0]   psum_q, psum_d, psum_c, sum;
  logic [bmp_tvf_pkg::ROW_W-1:0]   row_q, row_d, row_c, row_new;
  logic [bmp_tvf_pkg::ADDR_W-1:0]  col_q, col_d, col_c;
  logic [bmp_tvf_pkg::SIDE_W-1:0]  rcnt_q, rcnt_d, rcnt_c, side;
  logic                            done_q, done_d, done_c;
  logic                            pix;

  // clamp side to 1..MAX_SIDE
  always_comb begin
    if (image_side_i == '0) begin
      side = bmp_tvf_pkg::SIDE_W'(1);
    end else if (image_side_i > bmp_tvf_pkg::SIDE_W'(bmp_tvf_pkg::MAX_SIDE)) begin
      side = bmp_tvf_pkg::SIDE_W'(bmp_tvf_pkg::MAX_SIDE);
    end else begin
      side = image_side_i;
    end
  end

  always_comb begin
    // start of file clears everything before the byte is handled
    hdr_c   = start_of_file_i ? '0 : hdr_q;
    phase_c = start_of_file_i ? '0 : phase_q;
    psum_c  = start_of_file_i ? '0 : psum_q;
    row_c   = start_of_file_i ? '0 : row_q;
    col_c   = start_of_file_i ? '0 : col_q;
    rcnt_c  = start_of_file_i ? '0 : rcnt_q;
    done_c  = start_of_file_i ? 1'b0 : done_q;

    sum     = psum_c + bmp_tvf_pkg::SUM_W'(data_byte_i);
    pix     = (sum >= threshold_i);
    row_new = row_c | (bmp_tvf_pkg::ROW_W'(pix) << col_c);

    hdr_d   = hdr_q;
    phase_d = phase_q;
    psum_d  = psum_q;
    row_d   = row_q;
    col_d   = col_q;
    rcnt_d  = rcnt_q;
    done_d  = done_q;

    row_wr_o.we   = 1'b0;
    row_wr_o.addr = rcnt_c[bmp_tvf_pkg::ADDR_W-1:0];
    row_wr_o.data = row_new;
    row_wr_o.done = 1'b0;
    row_wr_o.side = side;

    if (in_fire_i) begin
      hdr_d   = hdr_c;
      phase_d = phase_c;
      psum_d  = psum_c;
      row_d   = row_c;
      col_d   = col_c;
      rcnt_d  = rcnt_c;
      done_d  = done_c;
      if (done_c) begin
        // frame complete: bytes dropped until next start of file
      end else if (hdr_c < bmp_tvf_pkg::HDR_W'(bmp_tvf_pkg::HEADER_BYTES)) begin
        hdr_d = hdr_c + bmp_tvf_pkg::HDR_W'(1);
      end else if (phase_c < bmp_tvf_pkg::PHASE_W'(2)) begin
        phase_d = phase_c + bmp_tvf_pkg::PHASE_W'(1);
        psum_d  = sum;
      end else begin
        phase_d = '0;
        psum_d  = '0;
        if ((bmp_tvf_pkg::SIDE_W'(col_c) + bmp_tvf_pkg::SIDE_W'(1)) < side) begin
          col_d = col_c + bmp_tvf_pkg::ADDR_W'(1);
          row_d = row_new;
        end else begin
          row_wr_o.we = 1'b1;
          row_d  = '0;
          col_d  = '0;
          rcnt_d = rcnt_c + bmp_tvf_pkg::SIDE_W'(1);
          if (rcnt_d >= side) begin
            done_d        = 1'b1;
            row_wr_o.done = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      phase_q <= '0;
      psum_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      rcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      hdr_q   <= hdr_d;
      phase_q <= phase_d;
      psum_q  <= psum_d;
      row_q   <= row_d;
      col_q   <= col_d;
      rcnt_q  <= rcnt_d;
      done_q  <= done_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/bmp_tvf_store.sv =====
`default_nettype none
module bmp_tvf_store (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bmp_tvf_pkg::row_wr_t                 row_wr_i,
  output logic                                      idle_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [bmp_tvf_pkg::ROW_W-1:0]             row_bits_o,
  output logic [bmp_tvf_pkg::ADDR_W-1:0]            row_index_o,
  output logic                                      last_row_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [bmp_tvf_pkg::ROW_W-1:0]  mem [bmp_tvf_pkg::MAX_SIDE];
  logic [bmp_tvf_pkg::ROW_W-1:0]  rd_q;
  logic [bmp_tvf_pkg::ROW_W-1:0]  mask_q, mask_d;
  logic [1:0]                     state_q, state_d;
  logic [bmp_tvf_pkg::ADDR_W-1:0] k_q, k_d;
  logic [bmp_tvf_pkg::SIDE_W-1:0] side_q, side_d, rd_addr_w;
  logic                           rd_en, last;

  // rows go out newest first
  assign rd_addr_w = side_q - bmp_tvf_pkg::SIDE_W'(1) - bmp_tvf_pkg::SIDE_W'(k_q);
  assign last      = (bmp_tvf_pkg::SIDE_W'(k_q) + bmp_tvf_pkg::SIDE_W'(1)) == side_q;
  assign rd_en     = (state_q == S_RD);

  always_ff @(posedge clk_i) begin
    if (row_wr_i.we) begin
      mem[row_wr_i.addr] <= row_wr_i.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr_w[bmp_tvf_pkg::ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    side_d  = side_q;
    mask_d  = mask_q;
    unique case (state_q)
      S_IDLE: begin
        if (row_wr_i.done) begin
          state_d = S_RD;
          k_d     = '0;
          side_d  = row_wr_i.side;
          mask_d  = bmp_tvf_pkg::side_mask(row_wr_i.side);
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
            k_d     = k_q + bmp_tvf_pkg::ADDR_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      side_q  <= bmp_tvf_pkg::SIDE_W'(1);
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      side_q  <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign row_bits_o  = rd_q & mask_q;
  assign row_index_o = k_q;
  assign last_row_o  = last;

endmodule
`default_nettype wire

// ===== src/bmp_threshold_vertical_flip.sv =====
// Bitmap binariser with vertical flip.
// Input channel (in_valid_i/in_ready_o): one file byte per word, start_of_file_i
// set on the first byte. The first 138 bytes are skipped, then each group of
// three bytes is summed and compared with the threshold register to give one
// pixel. Pixels fill rows of image_side columns; image_side rows make a frame.
// Loading takes one byte per cycle while in_ready_o is high.
// When the last row is stored the frame is read out on the output channel
// (out_valid_o/out_ready_i), last stored row first, one 64-bit row word per
// result, with row_index_o counting up and last_row_o on the final row.
// After the final pixel byte, and for each row, the store first reads the frame
// store into a register, then holds the row on the output until it is taken;
// the next row is read only after that. in_ready_o is low for
// the whole readout; a stalled receiver simply holds the current row.
// Further bytes after a frame are dropped until the next start_of_file_i.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_addr_i (0 threshold,
// 1 image_side); write only while idle.
// Reset: threshold 384, image_side 64, counters cleared, no readout pending.
// The frame store has no reset; only rows of the current frame are read.
`default_nettype none
module bmp_threshold_vertical_flip (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_addr_i,
  input  wire logic [bmp_tvf_pkg::THR_W-1:0]        cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [7:0]                           data_byte_i,
  input  wire logic                                 start_of_file_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [bmp_tvf_pkg::ROW_W-1:0]             row_bits_o,
  output logic [bmp_tvf_pkg::ADDR_W-1:0]            row_index_o,
  output logic                                      last_row_o
);

  logic [bmp_tvf_pkg::THR_W-1:0]  threshold_q;
  logic [bmp_tvf_pkg::SIDE_W-1:0] image_side_q;
  bmp_tvf_pkg::row_wr_t           row_wr;
  logic                           idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= bmp_tvf_pkg::THRESHOLD_RST;
      image_side_q <= bmp_tvf_pkg::IMAGE_SIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bmp_tvf_pkg::CFG_THRESHOLD: begin
          threshold_q <= cfg_wdata_i;
        end
        bmp_tvf_pkg::CFG_IMAGE_SIDE: begin
          image_side_q <= cfg_wdata_i[bmp_tvf_pkg::SIDE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = idle;

  bmp_tvf_pixel u_pixel (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_valid_i && idle),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .threshold_i     (threshold_q),
    .image_side_i    (image_side_q),
    .row_wr_o        (row_wr)
  );

  bmp_tvf_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_wr_i    (row_wr),
    .idle_o      (idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_bits_o  (row_bits_o),
    .row_index_o (row_index_o),
    .last_row_o  (last_row_o)
  );

endmodule
`default_nettype wire

// ===== src/bmp_tvf_checker.sv =====
`default_nettype none
module bmp_tvf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [5:0]  row_index_o,
  input wire logic        last_row_o
);

  // readout and loading never overlap
  a_no_load_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a row word is pending");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o)
      && $stable(last_row_o))
    else $error("row word changed under stall");

  a_more_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> !in_ready_o)
    else $error("readout ended before last row");

  a_row_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |-> ##2
      (out_valid_o && row_index_o == 6'($past(row_index_o, 2) + 6'd1)))
    else $error("row index did not step by one");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_row_o |=> !out_valid_o && in_ready_o)
    else $error("readout continued after last row");

endmodule

bind bmp_threshold_vertical_flip bmp_tvf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_index_o (row_index_o),
  .last_row_o  (last_row_o)
);
`default_nettype wire
